/* src/pbta_pkg.sv */
// Package for the paged block table allocator: item structs, codes, geometry
// constants and state encoding. No dependencies.
package pbta_pkg;

   localparam int BLOCK_TOKENS = 16;
   localparam int SLOT_W       = $clog2(BLOCK_TOKENS);
   localparam int TABLE_DEPTH  = 4096;
   localparam int TABLE_AW     = $clog2(TABLE_DEPTH);
   localparam int POOL_DEPTH   = 4096;
   localparam int POOL_AW      = $clog2(POOL_DEPTH);
   localparam int BLOCK_ID_W   = 12;
   localparam int ENTRY_W      = BLOCK_ID_W + 1;
   localparam int MAX_LAYERS   = 64;
   localparam int MAX_HEADS    = 64;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int MUL_W        = 27;

   localparam logic [6:0]  RESET_NUM_LAYERS     = 7'd64;
   localparam logic [6:0]  RESET_NUM_HEADS      = 7'd1;
   localparam logic [12:0] RESET_BLOCKS_PER_SEQ = 13'd64;
   localparam logic [12:0] RESET_POOL_BLOCKS    = 13'd4096;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_EVICT  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NOFREE   = 2'd1,
      STS_UNMAPPED = 2'd2,
      STS_RANGE    = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_LAYERS     = 2'd0,
      CSR_NUM_HEADS      = 2'd1,
      CSR_BLOCKS_PER_SEQ = 2'd2,
      CSR_POOL_BLOCKS    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_MUL_ROW,
      S_MUL_IDX,
      S_CHECK,
      S_READ,
      S_POP,
      S_EV_RD,
      S_EV_CHK,
      S_EV_NEXT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  layer_index;
      logic [5:0]  head_index;
      logic [15:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] phys_block;
      logic [3:0]  slot_offset;
      logic [16:0] seq_length;
      logic [12:0] blocks_in_use;
   } rsp_type;

endpackage

/* src/paged_block_table_allocator.sv */
// Paged block table allocator: page table, free stack and sequencer.
// Depends on pbta_pkg and pbta_ram.
//
// After reset the block sweeps the page table clear, one entry a cycle, with
// busy high; configuration writes are taken throughout. An item is taken when
// start is high and busy low, and busy stays high until its one result has been
// produced. A lookup passes the row and index multiply states, a range check
// and a table read; an insert adds a pop state when a freed block is popped off
// the stack; an index past the table stops at the check, and any other
// out-of-range or unknown command goes straight to done. Each ends with done,
// then the strobe. Busy drops in the strobe cycle, so the next item can be
// taken at the edge that ends it. Evict walks every layer and head row by row:
// both multiply states, a read and a check-and-free state per table entry
// visited, since the page table has a single read port, and a final read and a
// next-row state to close the row; after the last row come done and the strobe.
// One shared 13x13 multiply-add forms all table indexes. The result is on
// rsp_item for exactly one cycle with rsp_valid high and cannot be held off.
module paged_block_table_allocator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  pbta_pkg::req_type                      req_item,
   output logic                                   rsp_valid,
   output pbta_pkg::rsp_type                      rsp_item,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pbta_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [pbta_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int AW  = pbta_pkg::TABLE_AW;
   localparam int PW  = pbta_pkg::POOL_AW;
   localparam int EW  = pbta_pkg::ENTRY_W;
   localparam int BW  = pbta_pkg::BLOCK_ID_W;
   localparam int MW  = pbta_pkg::MUL_W;
   localparam int SW  = pbta_pkg::SLOT_W;

   pbta_pkg::state_type state_ff, state_in;

   logic [6:0]  num_layers_ff, num_heads_ff;
   logic [12:0] bps_ff, pool_blocks_ff;

   logic [1:0]    op_ff;
   logic [15:0]   pos_ff;
   logic [6:0]    a_ff, a_in;
   logic [6:0]    c_ff, c_in;
   logic [12:0]   b_ff, b_in;
   logic [MW-1:0] mul_ff, mul_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [12:0]   free_ff, free_in;
   logic [12:0]   fresh_ff, fresh_in;
   logic [16:0]   seq_ff, seq_in;
   logic [1:0]    sts_ff, sts_in;
   logic [BW-1:0] bid_ff, bid_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          rsp_valid_ff;
   pbta_pkg::rsp_type rsp_ff;

   logic          pt_we;
   logic [AW-1:0] pt_waddr, pt_raddr;
   logic [EW-1:0] pt_wdata, pt_rdata;
   logic          fs_we;
   logic [PW-1:0] fs_waddr, fs_raddr;
   logic [BW-1:0] fs_wdata, fs_rdata;

   logic [6:0]    lim_l, lim_h;
   logic [12:0]   lim_pool, nb;
   logic [11:0]   lb_ff;
   logic          accept, in_range;
   logic [12:0]   mul_x, mul_y, mul_add;
   logic [MW-1:0] ev_sum;
   logic [16:0]   seq_cand;

   pbta_ram #(.WIDTH(EW), .DEPTH(pbta_pkg::TABLE_DEPTH)) u_page_table (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   pbta_ram #(.WIDTH(BW), .DEPTH(pbta_pkg::POOL_DEPTH)) u_free_stack (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fs_waddr),
      .wr_data (fs_wdata),
      .rd_addr (fs_raddr),
      .rd_data (fs_rdata)
   );

   assign lim_l    = (num_layers_ff > 7'(pbta_pkg::MAX_LAYERS)) ?
                     7'(pbta_pkg::MAX_LAYERS) : num_layers_ff;
   assign lim_h    = (num_heads_ff > 7'(pbta_pkg::MAX_HEADS)) ?
                     7'(pbta_pkg::MAX_HEADS) : num_heads_ff;
   assign lim_pool = (pool_blocks_ff > 13'(pbta_pkg::POOL_DEPTH)) ?
                     13'(pbta_pkg::POOL_DEPTH) : pool_blocks_ff;
   assign lb_ff    = pos_ff[15:SW];
   assign nb       = ({1'b0, lb_ff} < bps_ff) ? {1'b0, lb_ff} : bps_ff;
   assign accept   = start && (state_ff == pbta_pkg::S_IDLE);
   assign in_range = ({1'b0, req_item.layer_index} < lim_l) &&
                     ({1'b0, req_item.head_index} < lim_h) &&
                     ({1'b0, req_item.position[15:SW]} < bps_ff);
   assign ev_sum   = mul_ff + MW'(b_ff);
   assign seq_cand = 17'(pos_ff) + 17'd1;

   // shared multiply-add: row = layer*heads + head, then index = row*bps + block
   always_comb begin
      if (state_ff == pbta_pkg::S_MUL_ROW) begin
         mul_x   = {6'd0, a_ff};
         mul_y   = {6'd0, num_heads_ff};
         mul_add = {6'd0, c_ff};
      end else begin
         mul_x   = mul_ff[12:0];
         mul_y   = bps_ff;
         mul_add = (op_ff == pbta_pkg::OP_EVICT) ? 13'd0 : {1'b0, lb_ff};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pbta_pkg::S_CLEAR: begin
            if (clr_ff == AW'(pbta_pkg::TABLE_DEPTH - 1)) state_in = pbta_pkg::S_IDLE;
         end
         pbta_pkg::S_IDLE: begin
            if (start) begin
               if (req_item.operation == pbta_pkg::OP_EVICT) begin
                  state_in = (lim_l == 7'd0 || lim_h == 7'd0) ?
                             pbta_pkg::S_DONE : pbta_pkg::S_MUL_ROW;
               end else if (req_item.operation == pbta_pkg::OP_UNUSED || !in_range) begin
                  state_in = pbta_pkg::S_DONE;
               end else begin
                  state_in = pbta_pkg::S_MUL_ROW;
               end
            end
         end
         pbta_pkg::S_MUL_ROW: state_in = pbta_pkg::S_MUL_IDX;
         pbta_pkg::S_MUL_IDX: begin
            state_in = (op_ff == pbta_pkg::OP_EVICT) ? pbta_pkg::S_EV_RD : pbta_pkg::S_CHECK;
         end
         pbta_pkg::S_CHECK: begin
            state_in = (mul_ff >= MW'(pbta_pkg::TABLE_DEPTH)) ?
                       pbta_pkg::S_DONE : pbta_pkg::S_READ;
         end
         pbta_pkg::S_READ: begin
            if (op_ff == pbta_pkg::OP_INSERT && !pt_rdata[EW-1] && free_ff != 13'd0) begin
               state_in = pbta_pkg::S_POP;
            end else begin
               state_in = pbta_pkg::S_DONE;
            end
         end
         pbta_pkg::S_POP: state_in = pbta_pkg::S_DONE;
         pbta_pkg::S_EV_RD: begin
            if (b_ff >= nb || ev_sum >= MW'(pbta_pkg::TABLE_DEPTH)) begin
               state_in = pbta_pkg::S_EV_NEXT;
            end else begin
               state_in = pbta_pkg::S_EV_CHK;
            end
         end
         pbta_pkg::S_EV_CHK: state_in = pbta_pkg::S_EV_RD;
         pbta_pkg::S_EV_NEXT: begin
            if (c_ff + 7'd1 < lim_h || a_ff + 7'd1 < lim_l) begin
               state_in = pbta_pkg::S_MUL_ROW;
            end else begin
               state_in = pbta_pkg::S_DONE;
            end
         end
         pbta_pkg::S_DONE: state_in = pbta_pkg::S_IDLE;
         default: state_in = pbta_pkg::S_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      a_in     = a_ff;
      c_in     = c_ff;
      b_in     = b_ff;
      mul_in   = mul_ff;
      addr_in  = addr_ff;
      clr_in   = clr_ff;
      free_in  = free_ff;
      fresh_in = fresh_ff;
      seq_in   = seq_ff;
      sts_in   = sts_ff;
      bid_in   = bid_ff;
      slot_in  = slot_ff;
      pt_we    = 1'b0;
      pt_waddr = addr_ff;
      pt_wdata = '0;
      pt_raddr = addr_ff;
      fs_we    = 1'b0;
      fs_waddr = free_ff[PW-1:0];
      fs_wdata = pt_rdata[BW-1:0];
      fs_raddr = PW'(free_ff - 13'd1);

      unique case (state_ff)
         pbta_pkg::S_CLEAR: begin
            pt_we    = 1'b1;
            pt_waddr = clr_ff;
            clr_in   = clr_ff + AW'(1);
         end
         pbta_pkg::S_IDLE: begin
            if (start) begin
               bid_in = '0;
               if (req_item.operation == pbta_pkg::OP_EVICT) begin
                  a_in    = '0;
                  c_in    = '0;
                  sts_in  = pbta_pkg::STS_OK;
                  slot_in = '0;
               end else begin
                  a_in    = {1'b0, req_item.layer_index};
                  c_in    = {1'b0, req_item.head_index};
                  sts_in  = pbta_pkg::STS_RANGE;
                  slot_in = '0;
               end
            end
         end
         pbta_pkg::S_MUL_ROW, pbta_pkg::S_MUL_IDX: begin
            mul_in = MW'(mul_x) * MW'(mul_y) + MW'(mul_add);
            b_in   = '0;
         end
         pbta_pkg::S_CHECK: begin
            pt_raddr = mul_ff[AW-1:0];
            addr_in  = mul_ff[AW-1:0];
         end
         pbta_pkg::S_READ: begin
            slot_in = pos_ff[SW-1:0];
            if (op_ff == pbta_pkg::OP_LOOKUP) begin
               if (pt_rdata[EW-1]) begin
                  sts_in = pbta_pkg::STS_OK;
                  bid_in = pt_rdata[BW-1:0];
               end else begin
                  sts_in = pbta_pkg::STS_UNMAPPED;
               end
            end else if (pt_rdata[EW-1]) begin
               sts_in = pbta_pkg::STS_OK;
               bid_in = pt_rdata[BW-1:0];
               if (seq_cand > seq_ff) seq_in = seq_cand;
            end else if (free_ff != 13'd0) begin
               // pop: stack read issued now, data lands next cycle
               free_in = free_ff - 13'd1;
            end else if (fresh_ff < lim_pool) begin
               pt_we    = 1'b1;
               pt_wdata = {1'b1, fresh_ff[BW-1:0]};
               fresh_in = fresh_ff + 13'd1;
               sts_in   = pbta_pkg::STS_OK;
               bid_in   = fresh_ff[BW-1:0];
               if (seq_cand > seq_ff) seq_in = seq_cand;
            end else begin
               sts_in = pbta_pkg::STS_NOFREE;
            end
         end
         pbta_pkg::S_POP: begin
            pt_we    = 1'b1;
            pt_wdata = {1'b1, fs_rdata};
            sts_in   = pbta_pkg::STS_OK;
            bid_in   = fs_rdata;
            if (seq_cand > seq_ff) seq_in = seq_cand;
         end
         pbta_pkg::S_EV_RD: begin
            pt_raddr = ev_sum[AW-1:0];
            addr_in  = ev_sum[AW-1:0];
         end
         pbta_pkg::S_EV_CHK: begin
            if (pt_rdata[EW-1] && free_ff < 13'(pbta_pkg::POOL_DEPTH)) begin
               fs_we   = 1'b1;
               pt_we   = 1'b1;
               free_in = free_ff + 13'd1;
            end
            b_in = b_ff + 13'd1;
         end
         pbta_pkg::S_EV_NEXT: begin
            if (c_ff + 7'd1 < lim_h) begin
               c_in = c_ff + 7'd1;
            end else begin
               a_in = a_ff + 7'd1;
               c_in = '0;
            end
         end
         pbta_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pbta_pkg::S_CLEAR;
         clr_ff         <= '0;
         free_ff        <= '0;
         fresh_ff       <= '0;
         seq_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         num_layers_ff  <= pbta_pkg::RESET_NUM_LAYERS;
         num_heads_ff   <= pbta_pkg::RESET_NUM_HEADS;
         bps_ff         <= pbta_pkg::RESET_BLOCKS_PER_SEQ;
         pool_blocks_ff <= pbta_pkg::RESET_POOL_BLOCKS;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         fresh_ff     <= fresh_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= (state_ff == pbta_pkg::S_DONE);
         if (csr_valid) begin
            unique case (pbta_pkg::csr_index_type'(csr_index))
               pbta_pkg::CSR_NUM_LAYERS:     num_layers_ff  <= csr_data[6:0];
               pbta_pkg::CSR_NUM_HEADS:      num_heads_ff   <= csr_data[6:0];
               pbta_pkg::CSR_BLOCKS_PER_SEQ: bps_ff         <= csr_data;
               pbta_pkg::CSR_POOL_BLOCKS:    pool_blocks_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_item.operation;
         pos_ff <= req_item.position;
      end
      a_ff    <= a_in;
      c_ff    <= c_in;
      b_ff    <= b_in;
      mul_ff  <= mul_in;
      addr_ff <= addr_in;
      sts_ff  <= sts_in;
      bid_ff  <= bid_in;
      slot_ff <= slot_in;
      if (state_ff == pbta_pkg::S_DONE) begin
         rsp_ff.status        <= sts_ff;
         rsp_ff.phys_block    <= bid_ff;
         rsp_ff.slot_offset   <= slot_ff;
         rsp_ff.seq_length    <= seq_ff;
         rsp_ff.blocks_in_use <= fresh_ff - free_ff;
      end
   end

   assign busy      = (state_ff != pbta_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

/* src/pbta_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module pbta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/paged_block_table_allocator_test.sv */
// Self-checking bench for the paged block table allocator: random and directed
// commands with a page table and free stack kept alongside. Depends on pbta_pkg.
module paged_block_table_allocator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   pbta_pkg::req_type req_item = '0;
   logic rsp_valid;
   pbta_pkg::rsp_type rsp_item;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pbta_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pbta_pkg::CSR_DATA_W-1:0] csr_data = '0;

   paged_block_table_allocator i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // mirror of the allocator state
   logic [pbta_pkg::ENTRY_W-1:0]    mapping [pbta_pkg::TABLE_DEPTH];
   logic [pbta_pkg::BLOCK_ID_W-1:0] freed_blocks [pbta_pkg::POOL_DEPTH];
   int unsigned freed_count, next_fresh, seq_len;
   int unsigned layers_cfg, heads_cfg, seq_blocks_cfg, pool_cfg;

   pbta_pkg::req_type pending_items[$];
   pbta_pkg::rsp_type awaited_rsps[$];
   int  mismatches = 0;
   bit  no_idle = 1'b0;
   int  quiet_cycles = 0;
   bit  progressed;

   function automatic int unsigned min_u(int unsigned a, int unsigned b);
      return a < b ? a : b;
   endfunction

   function automatic pbta_pkg::rsp_type allocator_result(pbta_pkg::status_type st,
                                                          int unsigned bid,
                                                          int unsigned slot);
      pbta_pkg::rsp_type r;
      r.status        = st;
      r.phys_block    = bid[11:0];
      r.slot_offset   = slot[3:0];
      r.seq_length    = seq_len[16:0];
      r.blocks_in_use = 13'(next_fresh - freed_count);
      return r;
   endfunction

   function automatic pbta_pkg::rsp_type predict_command(pbta_pkg::req_type it);
      int unsigned lb, slot, nb, bid;
      longint unsigned idx;
      logic [pbta_pkg::ENTRY_W-1:0] e;
      lb   = it.position / pbta_pkg::BLOCK_TOKENS;
      slot = it.position % pbta_pkg::BLOCK_TOKENS;
      if (it.operation == pbta_pkg::OP_EVICT) begin
         nb = min_u(lb, seq_blocks_cfg);
         for (int unsigned a = 0; a < min_u(layers_cfg, pbta_pkg::MAX_LAYERS); a++)
            for (int unsigned c = 0; c < min_u(heads_cfg, pbta_pkg::MAX_HEADS); c++)
               for (int unsigned b = 0; b < nb; b++) begin
                  idx = (longint'(a) * heads_cfg + c) * seq_blocks_cfg + b;
                  if (idx >= pbta_pkg::TABLE_DEPTH) break;
                  if (mapping[idx][pbta_pkg::BLOCK_ID_W] &&
                      freed_count < pbta_pkg::POOL_DEPTH) begin
                     freed_blocks[freed_count] = mapping[idx][pbta_pkg::BLOCK_ID_W-1:0];
                     freed_count++;
                     mapping[idx] = '0;
                  end
               end
         return allocator_result(pbta_pkg::STS_OK, 0, 0);
      end
      if (it.operation == pbta_pkg::OP_UNUSED ||
          it.layer_index >= min_u(layers_cfg, pbta_pkg::MAX_LAYERS) ||
          it.head_index >= min_u(heads_cfg, pbta_pkg::MAX_HEADS) || lb >= seq_blocks_cfg)
         return allocator_result(pbta_pkg::STS_RANGE, 0, 0);
      idx = (longint'(it.layer_index) * heads_cfg + it.head_index) * seq_blocks_cfg + lb;
      if (idx >= pbta_pkg::TABLE_DEPTH) return allocator_result(pbta_pkg::STS_RANGE, 0, 0);
      e = mapping[idx];
      if (it.operation == pbta_pkg::OP_LOOKUP) begin
         if (e[pbta_pkg::BLOCK_ID_W])
            return allocator_result(pbta_pkg::STS_OK, e[pbta_pkg::BLOCK_ID_W-1:0], slot);
         return allocator_result(pbta_pkg::STS_UNMAPPED, 0, slot);
      end
      if (!e[pbta_pkg::BLOCK_ID_W]) begin
         if (freed_count > 0) begin
            freed_count--;
            bid = freed_blocks[freed_count];
         end else if (next_fresh < min_u(pool_cfg, pbta_pkg::POOL_DEPTH)) begin
            bid = next_fresh;
            next_fresh++;
         end else begin
            return allocator_result(pbta_pkg::STS_NOFREE, 0, slot);
         end
         e = {1'b1, bid[11:0]};
         mapping[idx] = e;
      end
      if (it.position + 1 > seq_len) seq_len = it.position + 1;
      return allocator_result(pbta_pkg::STS_OK, e[pbta_pkg::BLOCK_ID_W-1:0], slot);
   endfunction

   // driver: present the oldest pending item, idling at random
   always @(negedge clock) begin
      if (!reset && pending_items.size() > 0 &&
          (no_idle || $urandom_range(0, 99) >= 35)) begin
         start    <= 1'b1;
         req_item <= pending_items[0];
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: predict on accept, check each result strobe
   always @(posedge clock) begin
      if (!reset) begin
         progressed = 1'b0;
         if (csr_valid && csr_ready) begin
            progressed = 1'b1;
            case (csr_index)
               pbta_pkg::CSR_NUM_LAYERS:     layers_cfg     = csr_data[6:0];
               pbta_pkg::CSR_NUM_HEADS:      heads_cfg      = csr_data[6:0];
               pbta_pkg::CSR_BLOCKS_PER_SEQ: seq_blocks_cfg = csr_data;
               pbta_pkg::CSR_POOL_BLOCKS:    pool_cfg       = csr_data;
            endcase
         end
         if (start && !busy) begin
            progressed = 1'b1;
            awaited_rsps.push_back(predict_command(req_item));
            void'(pending_items.pop_front());
         end
         if (rsp_valid) begin
            progressed = 1'b1;
            if (awaited_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %p", rsp_item);
            end else begin
               pbta_pkg::rsp_type want;
               want = awaited_rsps.pop_front();
               if (rsp_item.status !== want.status ||
                   rsp_item.phys_block !== want.phys_block ||
                   rsp_item.slot_offset !== want.slot_offset ||
                   rsp_item.seq_length !== want.seq_length ||
                   rsp_item.blocks_in_use !== want.blocks_in_use) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_item);
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         quiet_cycles <= progressed ? 0 : quiet_cycles + 1;
      end
   end

   task automatic write_csr(pbta_pkg::csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[pbta_pkg::CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_items();
      do @(posedge clock);
      while (pending_items.size() != 0 || awaited_rsps.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_geometry(int unsigned nl, int unsigned nh, int unsigned bps,
                               int unsigned pool);
      drain_items();
      write_csr(pbta_pkg::CSR_NUM_LAYERS, nl);
      write_csr(pbta_pkg::CSR_NUM_HEADS, nh);
      write_csr(pbta_pkg::CSR_BLOCKS_PER_SEQ, bps);
      write_csr(pbta_pkg::CSR_POOL_BLOCKS, pool);
   endtask

   function automatic pbta_pkg::req_type make_cmd(pbta_pkg::op_type op, int unsigned l,
                                                  int unsigned h, int unsigned pos);
      pbta_pkg::req_type it;
      it.operation   = op;
      it.layer_index = l[5:0];
      it.head_index  = h[5:0];
      it.position    = pos[15:0];
      return it;
   endfunction

   // mostly well-formed accesses inside the current geometry, some noise
   function automatic pbta_pkg::req_type random_cmd();
      int unsigned r, lb;
      r = $urandom_range(0, 99);
      if (r < 2)
         return make_cmd(pbta_pkg::OP_EVICT, $urandom, $urandom,
                         $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom);
      if (r < 5) return make_cmd(pbta_pkg::OP_UNUSED, $urandom, $urandom, $urandom);
      if (r < 12)
         return make_cmd(pbta_pkg::op_type'($urandom_range(0, 1)), $urandom, $urandom,
                         $urandom);
      lb = $urandom_range(0, min_u(seq_blocks_cfg, 4096) - 1);
      return make_cmd(r < 60 ? pbta_pkg::OP_INSERT : pbta_pkg::OP_LOOKUP,
                      $urandom_range(0, min_u(layers_cfg, pbta_pkg::MAX_LAYERS) - 1),
                      $urandom_range(0, min_u(heads_cfg, pbta_pkg::MAX_HEADS) - 1),
                      lb * pbta_pkg::BLOCK_TOKENS +
                      $urandom_range(0, pbta_pkg::BLOCK_TOKENS - 1));
   endfunction

   task automatic queue_random(int n);
      repeat (n) begin
         pending_items.push_back(random_cmd());
         while (pending_items.size() > 8) @(posedge clock);
      end
   endtask

   initial begin
      layers_cfg     = pbta_pkg::RESET_NUM_LAYERS;
      heads_cfg      = pbta_pkg::RESET_NUM_HEADS;
      seq_blocks_cfg = pbta_pkg::RESET_BLOCKS_PER_SEQ;
      pool_cfg       = pbta_pkg::RESET_POOL_BLOCKS;
      freed_count = 0;
      next_fresh  = 0;
      seq_len     = 0;
      foreach (mapping[i]) mapping[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset geometry, map, reuse, range and evict cases
      pending_items.push_back(make_cmd(pbta_pkg::OP_LOOKUP, 0, 0, 0));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 0, 0, 0));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 0, 0, 15));
      pending_items.push_back(make_cmd(pbta_pkg::OP_LOOKUP, 0, 0, 7));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 63, 0, 1023));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 5, 0, 1024));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 0, 0, 65535));
      pending_items.push_back(make_cmd(pbta_pkg::OP_LOOKUP, 0, 63, 3));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 63, 63, 0));
      pending_items.push_back(make_cmd(pbta_pkg::OP_UNUSED, 0, 0, 0));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 2, 0, 16));
      pending_items.push_back(make_cmd(pbta_pkg::OP_EVICT, 63, 63, 16));
      pending_items.push_back(make_cmd(pbta_pkg::OP_LOOKUP, 0, 0, 0));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 7, 0, 40));
      pending_items.push_back(make_cmd(pbta_pkg::OP_EVICT, 0, 0, 65535));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 1, 0, 100));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 1, 0, 200));
      pending_items.push_back(make_cmd(pbta_pkg::OP_LOOKUP, 63, 0, 1023));
      no_idle = 1'b1;
      queue_random(200);
      no_idle = 1'b0;

      // smallest geometry: one block, pool of one
      set_geometry(1, 1, 1, 1);
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 0, 0, 3));
      pending_items.push_back(make_cmd(pbta_pkg::OP_INSERT, 0, 0, 16));
      queue_random(150);

      // small pool to force exhaustion
      set_geometry(4, 4, 16, 40);
      queue_random(250);

      // largest geometry: most indexes fall past the table
      set_geometry(64, 64, 4096, 4096);
      queue_random(150);

      set_geometry(64, 64, 1, 4096);
      queue_random(200);

      set_geometry(3, 5, 300, 100);
      queue_random(200);

      set_geometry($urandom_range(1, 64), $urandom_range(1, 64),
                   $urandom_range(1, 64), $urandom_range(1, 4096));
      queue_random(230);

      do @(posedge clock); while (pending_items.size() != 0 || awaited_rsps.size() != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

/* paged_block_table_allocator.f */
src/pbta_pkg.sv
src/pbta_ram.sv
src/paged_block_table_allocator.sv
test/paged_block_table_allocator_test.sv
